/* src/ufl_pkg.sv */
// Shared constants, types and controller state codes for the fill-level gauge.
package ufl_pkg;

    localparam int unsigned ECHO_W           = 15;
    localparam int unsigned HEIGHT_W         = 9;
    localparam int unsigned DIST_W           = 18;
    localparam int unsigned OUT_DIST_W       = 17;
    localparam int unsigned FILL_W           = 10;
    localparam int unsigned IDX_W            = 3;
    localparam int unsigned SLOT_W           = 2;
    localparam int unsigned HF_W             = HEIGHT_W + 8;
    localparam int unsigned NUM_W            = HF_W + FILL_W;
    localparam int unsigned DIV_CNT_W        = 4;

    localparam int unsigned PINGS_PER_SENSOR = 3;
    localparam int unsigned SET_LEN          = 2 * PINGS_PER_SENSOR;
    localparam int unsigned ECHO_TIMEOUT_US  = 30000;
    localparam int unsigned DIST_SCALE       = 281;
    localparam int unsigned DIST_SHIFT       = 6;
    localparam int unsigned HEIGHT_MARGIN_CM = 10;
    localparam int unsigned FILL_SCALE       = 1000;
    localparam int unsigned FILL_MAX         = 1000;
    localparam int unsigned OUT_DIST_MAX     = 131071;
    localparam int unsigned HEIGHT_RESET_CM  = 40;
    localparam int unsigned DIV_STEPS        = 10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_STORE,
        ST_MED_A,
        ST_MED_B,
        ST_AVG,
        ST_SCALE,
        ST_DIV,
        ST_OUT
    } ufl_state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic store;
        logic med_a;
        logic med_b;
        logic avg;
        logic scale;
        logic div_step;
        logic out_load;
    } ufl_cmd_t;

    typedef struct packed {
        logic a_end;
        logic set_end;
        logic div_last;
        logic out_busy;
    } ufl_status_t;

endpackage

/* src/ufl_datapath.sv */
// Datapath: ping distance, reading store, medians, average and fill divider.
module ufl_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ufl_pkg::ufl_cmd_t                 cmd,
    output ufl_pkg::ufl_status_t              status,
    input  logic [ufl_pkg::ECHO_W-1:0]        s_echo_us,
    input  logic                              s_first_of_set,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ufl_pkg::HEIGHT_W-1:0]      cfg_bin_height_cm,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ufl_pkg::FILL_W-1:0]        m_fill_permille,
    output logic [ufl_pkg::OUT_DIST_W-1:0]    m_median_a,
    output logic [ufl_pkg::OUT_DIST_W-1:0]    m_median_b,
    output logic                              m_a_valid,
    output logic                              m_b_valid
);
    import ufl_pkg::*;

    logic [HEIGHT_W-1:0]   height_reg;
    logic [ECHO_W-1:0]     echo_reg;
    logic                  echo_ok_reg;
    logic [IDX_W-1:0]      cur_idx_reg;
    logic [IDX_W-1:0]      ping_index_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [DIST_W-1:0]     readings_reg [PINGS_PER_SENSOR];
    logic [PINGS_PER_SENSOR-1:0] valid_reg;
    logic [DIST_W-1:0]     held_ma_reg;
    logic                  held_av_reg;
    logic [DIST_W-1:0]     mb_reg;
    logic                  bv_reg;
    logic [HF_W-1:0]       diff_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [FILL_W-1:0]     q_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic                  m_valid_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [OUT_DIST_W-1:0] ma_out_reg;
    logic [OUT_DIST_W-1:0] mb_out_reg;
    logic                  av_out_reg;
    logic                  bv_out_reg;

    logic [IDX_W-1:0]      cur_idx_next;
    logic [SLOT_W-1:0]     slot;
    logic [DIST_W-1:0]     dist_limit;
    logic [DIST_W-1:0]     dist_clamped;
    logic [ECHO_W+8:0]     product;
    logic [HF_W-1:0]       hf;
    logic [DIST_W-1:0]     lo01, hi01, med3, min02, min12;
    logic [DIST_W-1:0]     med_val;
    logic                  med_ok;
    logic [DIST_W:0]       sum;
    logic [DIST_W-1:0]     avg;
    logic                  any_valid;
    logic [NUM_W-1:0]      trial;

    assign cfg_ready = 1'b1;
    assign hf        = {height_reg, 8'd0};

    assign cur_idx_next = (s_first_of_set || ping_index_reg >= IDX_W'(SET_LEN))
                          ? '0 : ping_index_reg;
    assign slot = (cur_idx_reg >= IDX_W'(PINGS_PER_SENSOR))
                  ? SLOT_W'(cur_idx_reg - IDX_W'(PINGS_PER_SENSOR))
                  : SLOT_W'(cur_idx_reg);

    assign product      = echo_reg * (ECHO_W+9)'(DIST_SCALE);
    assign dist_limit   = DIST_W'({HEIGHT_W'(height_reg) + HEIGHT_W'(0), 8'd0})
                          + DIST_W'(HEIGHT_MARGIN_CM * 256);
    assign dist_clamped = (dist_reg > dist_limit) ? DIST_W'(hf) : dist_reg;

    always_comb begin
        lo01  = (readings_reg[0] < readings_reg[1]) ? readings_reg[0] : readings_reg[1];
        hi01  = (readings_reg[0] < readings_reg[1]) ? readings_reg[1] : readings_reg[0];
        min02 = (readings_reg[0] < readings_reg[2]) ? readings_reg[0] : readings_reg[2];
        min12 = (readings_reg[1] < readings_reg[2]) ? readings_reg[1] : readings_reg[2];
        if (readings_reg[2] < lo01) begin
            med3 = lo01;
        end else if (readings_reg[2] > hi01) begin
            med3 = hi01;
        end else begin
            med3 = readings_reg[2];
        end
        unique case (valid_reg)
            3'b111: begin
                med_ok  = 1'b1;
                med_val = med3;
            end
            3'b011: begin
                med_ok  = 1'b1;
                med_val = lo01;
            end
            3'b101: begin
                med_ok  = 1'b1;
                med_val = min02;
            end
            3'b110: begin
                med_ok  = 1'b1;
                med_val = min12;
            end
            default: begin
                med_ok  = 1'b0;
                med_val = '0;
            end
        endcase
    end

    always_comb begin
        sum       = (held_av_reg ? {1'b0, held_ma_reg} : '0) + (bv_reg ? {1'b0, mb_reg} : '0);
        avg       = (held_av_reg && bv_reg) ? sum[DIST_W:1] : sum[DIST_W-1:0];
        any_valid = held_av_reg || bv_reg;
        trial     = NUM_W'(hf) << div_cnt_reg;
    end

    assign status.a_end    = (cur_idx_reg == IDX_W'(PINGS_PER_SENSOR - 1));
    assign status.set_end  = (cur_idx_reg == IDX_W'(SET_LEN - 1));
    assign status.div_last = (div_cnt_reg == '0);
    assign status.out_busy = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg     <= HEIGHT_W'(HEIGHT_RESET_CM);
            ping_index_reg <= '0;
            valid_reg      <= '0;
            held_ma_reg    <= '0;
            held_av_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                height_reg <= cfg_bin_height_cm;
            end
            if (cmd.store) begin
                valid_reg[slot] <= echo_ok_reg;
                ping_index_reg  <= (cur_idx_reg == IDX_W'(SET_LEN - 1))
                                   ? '0 : cur_idx_reg + IDX_W'(1);
            end
            if (cmd.med_a) begin
                held_ma_reg <= med_val;
                held_av_reg <= med_ok;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            echo_reg    <= s_echo_us;
            echo_ok_reg <= (s_echo_us != '0) && (s_echo_us <= ECHO_W'(ECHO_TIMEOUT_US));
            cur_idx_reg <= cur_idx_next;
        end
        if (cmd.mul) begin
            dist_reg <= product[DIST_SHIFT +: DIST_W];
        end
        if (cmd.store) begin
            readings_reg[slot] <= echo_ok_reg ? dist_clamped : '0;
        end
        if (cmd.med_b) begin
            mb_reg <= med_val;
            bv_reg <= med_ok;
        end
        if (cmd.avg) begin
            diff_reg <= (any_valid && ({1'b0, avg} < (DIST_W+1)'(hf)))
                        ? HF_W'(hf - HF_W'(avg)) : '0;
        end
        if (cmd.scale) begin
            rem_reg     <= diff_reg * NUM_W'(FILL_SCALE);
            q_reg       <= '0;
            div_cnt_reg <= DIV_CNT_W'(DIV_STEPS - 1);
        end
        if (cmd.div_step) begin
            if (rem_reg != '0 && rem_reg >= trial) begin
                rem_reg            <= rem_reg - trial;
                q_reg[div_cnt_reg] <= 1'b1;
            end
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
        if (cmd.out_load) begin
            fill_reg   <= (q_reg > FILL_W'(FILL_MAX)) ? FILL_W'(FILL_MAX) : q_reg;
            ma_out_reg <= !held_av_reg ? '0 :
                          (held_ma_reg > DIST_W'(OUT_DIST_MAX)) ? OUT_DIST_W'(OUT_DIST_MAX)
                          : held_ma_reg[OUT_DIST_W-1:0];
            mb_out_reg <= !bv_reg ? '0 :
                          (mb_reg > DIST_W'(OUT_DIST_MAX)) ? OUT_DIST_W'(OUT_DIST_MAX)
                          : mb_reg[OUT_DIST_W-1:0];
            av_out_reg <= held_av_reg;
            bv_out_reg <= bv_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_fill_permille = fill_reg;
    assign m_median_a      = ma_out_reg;
    assign m_median_b      = mb_out_reg;
    assign m_a_valid       = av_out_reg;
    assign m_b_valid       = bv_out_reg;

endmodule

/* src/ufl_controller.sv */
// Controller: sequences each ping through the datapath and runs the fill division.
module ufl_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ufl_pkg::ufl_status_t status,
    output ufl_pkg::ufl_cmd_t    cmd
);
    import ufl_pkg::*;

    ufl_state_t state_reg;
    ufl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_STORE;
            ST_STORE: begin
                if (status.a_end) begin
                    state_next = ST_MED_A;
                end else if (status.set_end) begin
                    state_next = ST_MED_B;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MED_A: state_next = ST_IDLE;
            ST_MED_B: state_next = ST_AVG;
            ST_AVG:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_MUL:   cmd.mul      = 1'b1;
            ST_STORE: cmd.store    = 1'b1;
            ST_MED_A: cmd.med_a    = 1'b1;
            ST_MED_B: cmd.med_b    = 1'b1;
            ST_AVG:   cmd.avg      = 1'b1;
            ST_SCALE: cmd.scale    = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_OUT:   cmd.out_load = !status.out_busy;
            default:  cmd          = '0;
        endcase
    end

endmodule

/* src/ultrasonic_fill_level.sv */
// Top level of the ultrasonic fill-level gauge: controller plus datapath.
// Each accepted ping transaction runs capture, distance multiply and store; it adds median A
// when it closes the sensor A half-set, and closing a six-ping set adds median B,
// average, scale by 1000, a 10-step restoring divider by the bin height, and the result load.
// The result load also waits while an earlier result stays unaccepted.
// The controller takes one ping at a time; the result register holds a finished transaction
// while the next pings are taken. The height register is written through cfg_valid/cfg_ready.
module ultrasonic_fill_level (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ufl_pkg::ECHO_W-1:0]        s_echo_us,
    input  logic                              s_first_of_set,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ufl_pkg::HEIGHT_W-1:0]      cfg_bin_height_cm,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ufl_pkg::FILL_W-1:0]        m_fill_permille,
    output logic [ufl_pkg::OUT_DIST_W-1:0]    m_median_a,
    output logic [ufl_pkg::OUT_DIST_W-1:0]    m_median_b,
    output logic                              m_a_valid,
    output logic                              m_b_valid
);
    import ufl_pkg::*;

    ufl_cmd_t    cmd;
    ufl_status_t status;

    ufl_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ufl_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_echo_us         (s_echo_us),
        .s_first_of_set    (s_first_of_set),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_bin_height_cm (cfg_bin_height_cm),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_fill_permille   (m_fill_permille),
        .m_median_a        (m_median_a),
        .m_median_b        (m_median_b),
        .m_a_valid         (m_a_valid),
        .m_b_valid         (m_b_valid)
    );

endmodule
